FILE: sv/quaternion_to_rotation_matrix_assert.svh
// assertion macros for the quaternion to rotation matrix block
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define Q2R_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication with the consequent checked in the following cycle
`define Q2R_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/q2r_pkg.sv
package q2r_pkg;
   localparam int unsigned IN_W = 16;
   localparam int unsigned OUT_W = 16;
   localparam int unsigned ENTRIES = 9;
   localparam int unsigned PROD_W = 2 * IN_W;
   // norm is a sum of four squares, each at most 2^30
   localparam int unsigned NORM_W = PROD_W + 1;
   // numerators: twice a sum of two products, or four squares with signs
   localparam int unsigned NUM_W = PROD_W + 2;
   localparam int unsigned MAG_W = PROD_W + 1;

   typedef logic signed [IN_W-1:0] comp_type;
   typedef logic signed [OUT_W-1:0] entry_type;

   typedef struct packed {
      comp_type quat_w;
      comp_type quat_x;
      comp_type quat_y;
      comp_type quat_z;
   } quat_type;

   typedef struct packed {
      entry_type m00;
      entry_type m01;
      entry_type m02;
      entry_type m10;
      entry_type m11;
      entry_type m12;
      entry_type m20;
      entry_type m21;
      entry_type m22;
      logic degenerate;
   } matrix_type;
endpackage

FILE: sv/q2r_if.sv
interface q2r_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/quaternion_to_rotation_matrix.sv
// throughput: one request per cycle while the output skid is empty; two product stages, one divider stage per
//   quotient bit, one saturation stage and an output skid register
// reset: synchronous, clears only the valid bits; the data registers are not reset
module quaternion_to_rotation_matrix #(
   parameter int unsigned FRAC_BITS = 14
) (
   input logic clock,
   input logic reset,
   q2r_if.sink req,
   q2r_if.source rsp
);
   `include "quaternion_to_rotation_matrix_assert.svh"

   localparam int unsigned E = q2r_pkg::ENTRIES;
   localparam int unsigned QBITS = FRAC_BITS + 1;
   localparam int unsigned QW = (QBITS + 1 > 17) ? QBITS + 1 : 17;
   localparam int unsigned OW = q2r_pkg::OUT_W;

   logic advance;
   logic f_valid, d_valid;
   logic [q2r_pkg::NORM_W-1:0] f_norm, d_norm;
   logic [E-1:0] f_neg, d_neg;
   logic [E-1:0][q2r_pkg::MAG_W-1:0] f_mag;
   logic [E-1:0][QBITS-1:0] d_quot;
   logic s_valid_ff;
   q2r_pkg::matrix_type s_data_ff, s_data_in;
   logic k_valid_ff;
   q2r_pkg::matrix_type k_data_ff;
   logic [E-1:0][OW-1:0] ent;

   // pipeline moves unless the skid is full
   assign advance = !k_valid_ff;
   assign req.ready = advance;

   q2r_front u_front (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req.valid && req.ready), .in_quat(req.data),
      .out_valid(f_valid), .out_norm(f_norm), .out_neg(f_neg), .out_mag(f_mag)
   );

   q2r_divider #(.QBITS(QBITS)) u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(f_valid), .in_norm(f_norm), .in_neg(f_neg), .in_mag(f_mag),
      .out_valid(d_valid), .out_norm(d_norm), .out_neg(d_neg), .out_quot(d_quot)
   );

   always_comb begin
      logic [QW-1:0] q;
      logic [QW-1:0] lim;
      for (int k = 0; k < E; k++) begin
         q = QW'(d_quot[k]);
         lim = QW'(1) << FRAC_BITS;
         if (q > lim) q = lim;
         if (d_neg[k]) begin
            if (q > QW'(32768)) q = QW'(32768);
            ent[k] = OW'(-q);
         end else begin
            if (q > QW'(32767)) q = QW'(32767);
            ent[k] = OW'(q);
         end
         if (d_norm == '0) ent[k] = '0;
      end
      s_data_in.m00 = ent[0];
      s_data_in.m01 = ent[1];
      s_data_in.m02 = ent[2];
      s_data_in.m10 = ent[3];
      s_data_in.m11 = ent[4];
      s_data_in.m12 = ent[5];
      s_data_in.m20 = ent[6];
      s_data_in.m21 = ent[7];
      s_data_in.m22 = ent[8];
      s_data_in.degenerate = (d_norm == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (advance) begin
         s_valid_ff <= d_valid;
      end
      if (advance) begin
         s_data_ff <= s_data_in;
      end
   end

   // output skid: takes the final stage when the sink stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         k_valid_ff <= 1'b0;
      end else if (k_valid_ff) begin
         if (rsp.ready) k_valid_ff <= 1'b0;
      end else if (s_valid_ff && !rsp.ready) begin
         k_valid_ff <= 1'b1;
      end
      if (!k_valid_ff) begin
         k_data_ff <= s_data_ff;
      end
   end

   assign rsp.valid = k_valid_ff || s_valid_ff;
   assign rsp.data = k_valid_ff ? k_data_ff : s_data_ff;

   `Q2R_ASSERT_IMPL(a_skid_blocks, clock, reset, k_valid_ff, !req.ready,
      "request taken while skid full")
   `Q2R_ASSERT_IMPL(a_degen_zero, clock, reset,
      rsp.valid && rsp.data.degenerate, rsp.data.m00 == '0 && rsp.data.m11 == '0,
      "degenerate result with nonzero matrix")
   `Q2R_ASSERT_NEXT(a_skid_holds, clock, reset, k_valid_ff && !rsp.ready,
      k_valid_ff && $stable(k_data_ff), "skid lost a result")
endmodule

FILE: sv/q2r_front.sv
// squares, cross products, norm and numerators over two register stages
module q2r_front (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic in_valid,
   input q2r_pkg::quat_type in_quat,
   output logic out_valid,
   output logic [q2r_pkg::NORM_W-1:0] out_norm,
   output logic [q2r_pkg::ENTRIES-1:0] out_neg,
   output logic [q2r_pkg::ENTRIES-1:0][q2r_pkg::MAG_W-1:0] out_mag
);
   localparam int unsigned PW = q2r_pkg::PROD_W;
   localparam int unsigned NW = q2r_pkg::NUM_W;

   logic p_valid_ff;
   logic signed [9:0][PW-1:0] prod_ff;
   logic signed [9:0][PW-1:0] prod_in;
   logic n_valid_ff;
   logic [q2r_pkg::NORM_W-1:0] norm_ff, norm_in;
   logic [q2r_pkg::ENTRIES-1:0] neg_ff, neg_in;
   logic [q2r_pkg::ENTRIES-1:0][q2r_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic signed [q2r_pkg::ENTRIES-1:0][NW-1:0] num;
   logic signed [NW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;

   // ww xx yy zz xy wz xz wy yz wx
   always_comb begin
      prod_in[0] = in_quat.quat_w * in_quat.quat_w;
      prod_in[1] = in_quat.quat_x * in_quat.quat_x;
      prod_in[2] = in_quat.quat_y * in_quat.quat_y;
      prod_in[3] = in_quat.quat_z * in_quat.quat_z;
      prod_in[4] = in_quat.quat_x * in_quat.quat_y;
      prod_in[5] = in_quat.quat_w * in_quat.quat_z;
      prod_in[6] = in_quat.quat_x * in_quat.quat_z;
      prod_in[7] = in_quat.quat_w * in_quat.quat_y;
      prod_in[8] = in_quat.quat_y * in_quat.quat_z;
      prod_in[9] = in_quat.quat_w * in_quat.quat_x;
   end

   always_comb begin
      ww = NW'($signed(prod_ff[0]));
      xx = NW'($signed(prod_ff[1]));
      yy = NW'($signed(prod_ff[2]));
      zz = NW'($signed(prod_ff[3]));
      xy = NW'($signed(prod_ff[4]));
      wz = NW'($signed(prod_ff[5]));
      xz = NW'($signed(prod_ff[6]));
      wy = NW'($signed(prod_ff[7]));
      yz = NW'($signed(prod_ff[8]));
      wx = NW'($signed(prod_ff[9]));
      num[0] = ww + xx - yy - zz;
      num[1] = (xy - wz) <<< 1;
      num[2] = (xz + wy) <<< 1;
      num[3] = (xy + wz) <<< 1;
      num[4] = ww - xx + yy - zz;
      num[5] = (yz - wx) <<< 1;
      num[6] = (xz - wy) <<< 1;
      num[7] = (yz + wx) <<< 1;
      num[8] = ww - xx - yy + zz;
      norm_in = q2r_pkg::NORM_W'(ww + xx + yy + zz);
      for (int k = 0; k < q2r_pkg::ENTRIES; k++) begin
         neg_in[k] = num[k][NW-1];
         mag_in[k] = q2r_pkg::MAG_W'(num[k][NW-1] ? -num[k] : num[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         n_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= in_valid;
         n_valid_ff <= p_valid_ff;
      end
      if (advance) begin
         prod_ff <= prod_in;
         norm_ff <= norm_in;
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
   end

   assign out_valid = n_valid_ff;
   assign out_norm = norm_ff;
   assign out_neg = neg_ff;
   assign out_mag = mag_ff;
endmodule

FILE: sv/q2r_divider.sv
// pipelined restoring divider, one quotient bit per stage, all nine entries in lanes
module q2r_divider #(
   parameter int unsigned QBITS = 15
) (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic in_valid,
   input logic [q2r_pkg::NORM_W-1:0] in_norm,
   input logic [q2r_pkg::ENTRIES-1:0] in_neg,
   input logic [q2r_pkg::ENTRIES-1:0][q2r_pkg::MAG_W-1:0] in_mag,
   output logic out_valid,
   output logic [q2r_pkg::NORM_W-1:0] out_norm,
   output logic [q2r_pkg::ENTRIES-1:0] out_neg,
   output logic [q2r_pkg::ENTRIES-1:0][QBITS-1:0] out_quot
);
   localparam int unsigned E = q2r_pkg::ENTRIES;
   localparam int unsigned RW = q2r_pkg::NORM_W + 1;

   // stage s produces quotient bit QBITS-1-s; magnitude is below 2*norm
   logic valid_ff [QBITS+1];
   logic [q2r_pkg::NORM_W-1:0] norm_ff [QBITS+1];
   logic [E-1:0] neg_ff [QBITS+1];
   logic [E-1:0][RW-1:0] rem_ff [QBITS+1];
   logic [E-1:0][QBITS-1:0] quot_ff [QBITS+1];

   always_comb begin
      valid_ff[0] = in_valid;
      norm_ff[0] = in_norm;
      neg_ff[0] = in_neg;
      for (int k = 0; k < E; k++) begin
         rem_ff[0][k] = RW'(in_mag[k]);
         quot_ff[0][k] = '0;
      end
   end

   for (genvar s = 0; s < QBITS; s++) begin : g_stage
      logic [E-1:0][RW-1:0] rem_in;
      logic [E-1:0][QBITS-1:0] quot_in;
      logic [RW-1:0] trial;
      always_comb begin
         for (int k = 0; k < E; k++) begin
            // the first stage takes the whole magnitude, later ones shift in a zero
            if (s == 0) begin
               trial = rem_ff[s][k];
            end else begin
               trial = {rem_ff[s][k][RW-2:0], 1'b0};
            end
            if (trial >= RW'(norm_ff[s])) begin
               rem_in[k] = trial - RW'(norm_ff[s]);
               quot_in[k] = {quot_ff[s][k][QBITS-2:0], 1'b1};
            end else begin
               rem_in[k] = trial;
               quot_in[k] = {quot_ff[s][k][QBITS-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (advance) begin
            norm_ff[s+1] <= norm_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            rem_ff[s+1] <= rem_in;
            quot_ff[s+1] <= quot_in;
         end
      end
   end

   assign out_valid = valid_ff[QBITS];
   assign out_norm = norm_ff[QBITS];
   assign out_neg = neg_ff[QBITS];
   assign out_quot = quot_ff[QBITS];
endmodule

FILE: test/quaternion_to_rotation_matrix_tb.sv
module quaternion_to_rotation_matrix_tb;
   localparam int unsigned FRAC = 14;
   localparam int unsigned LATENCY = FRAC + 4;
   localparam int unsigned WATCHDOG_LIMIT = 5000;

   logic clock;
   logic reset;
   int unsigned fails = 0;
   int unsigned idle_cycles = 0;
   int unsigned rsp_stall = 0;
   bit timed_out;
   q2r_pkg::matrix_type expected_matrices[$];

   q2r_if #(.payload_type(q2r_pkg::quat_type)) req_chan ();
   q2r_if #(.payload_type(q2r_pkg::matrix_type)) rsp_chan ();

   quaternion_to_rotation_matrix #(.FRAC_BITS(FRAC)) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_chan.sink),
      .rsp(rsp_chan.source)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic q2r_pkg::entry_type scale_entry(longint signed num,
                                                      longint unsigned norm);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (mag << FRAC) / norm;
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      if (num < 0) begin
         if (q > 32768) q = 32768;
         return q2r_pkg::entry_type'(-longint'(q));
      end
      if (q > 32767) q = 32767;
      return q2r_pkg::entry_type'(q);
   endfunction

   function automatic q2r_pkg::matrix_type rotation_of(q2r_pkg::quat_type qt);
      longint signed w, x, y, z, ww, xx, yy, zz;
      longint unsigned norm;
      q2r_pkg::matrix_type m;
      w = qt.quat_w;
      x = qt.quat_x;
      y = qt.quat_y;
      z = qt.quat_z;
      ww = w * w;
      xx = x * x;
      yy = y * y;
      zz = z * z;
      norm = ww + xx + yy + zz;
      m = '0;
      if (norm == 0) begin
         m.degenerate = 1'b1;
         return m;
      end
      m.m00 = scale_entry(ww + xx - yy - zz, norm);
      m.m01 = scale_entry(2 * (x * y - w * z), norm);
      m.m02 = scale_entry(2 * (x * z + w * y), norm);
      m.m10 = scale_entry(2 * (x * y + w * z), norm);
      m.m11 = scale_entry(ww - xx + yy - zz, norm);
      m.m12 = scale_entry(2 * (y * z - w * x), norm);
      m.m20 = scale_entry(2 * (x * z - w * y), norm);
      m.m21 = scale_entry(2 * (y * z + w * x), norm);
      m.m22 = scale_entry(ww - xx - yy + zz, norm);
      return m;
   endfunction

   task automatic send_quat(q2r_pkg::comp_type w, q2r_pkg::comp_type x,
                            q2r_pkg::comp_type y, q2r_pkg::comp_type z);
      q2r_pkg::quat_type qt;
      int unsigned gap;
      qt = '{quat_w: w, quat_x: x, quat_y: y, quat_z: z};
      gap = gap_length();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= qt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_matrices.push_back(rotation_of(qt));
   endtask

   task automatic release_request();
      req_chan.valid <= 1'b0;
   endtask

   function automatic q2r_pkg::comp_type rand_comp();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return q2r_pkg::comp_type'(16'h8000);
      if (r == 1) return q2r_pkg::comp_type'(16'h7fff);
      if (r < 4) return q2r_pkg::comp_type'($urandom_range(0, 31) - 16);
      return q2r_pkg::comp_type'($urandom);
   endfunction

   task automatic test_extremes();
      q2r_pkg::comp_type vals[6];
      vals = '{16'sh0000, 16'sh4000, -16'sh4000, 16'sh7fff, 16'sh8000, 16'sh0001};
      send_quat(0, 0, 0, 0);
      send_quat(16'sh4000, 0, 0, 0);
      send_quat(0, 16'sh4000, 0, 0);
      send_quat(0, 0, 16'sh4000, 0);
      send_quat(0, 0, 0, 16'sh4000);
      send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_quat(16'sh0001, 0, 0, 0);
      send_quat(0, 0, 0, 16'sh8000);
      send_quat(16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000);
      send_quat(16'sh2d41, 16'sh2d41, 0, 0);
      send_quat(16'sh0001, -16'sh0001, 16'sh0001, -16'sh0001);
      for (int i = 0; i < 8; i++)
         send_quat(vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)],
                   vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)]);
      release_request();
   endtask

   task automatic test_random();
      for (int i = 0; i < 530; i++)
         send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      release_request();
   endtask

   // result side: random backpressure and in-order comparison
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_matrices.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_chan.data);
               fails++;
            end else begin
               q2r_pkg::matrix_type e;
               e = expected_matrices.pop_front();
               if (e !== rsp_chan.data) begin
                  $display("%0t: mismatch expected %h actual %h", $time, e,
                           rsp_chan.data);
                  fails++;
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall <= $urandom_range(10, 40);
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 9) < 7);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** quaternion_to_rotation_matrix: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_random();
      while (expected_matrices.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fails == 0) begin
         $display("** quaternion_to_rotation_matrix: PASSED **");
      end else begin
         $display("** quaternion_to_rotation_matrix: FAILED **");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+sv
sv/q2r_pkg.sv
sv/q2r_if.sv
sv/q2r_front.sv
sv/q2r_divider.sv
sv/quaternion_to_rotation_matrix.sv
test/quaternion_to_rotation_matrix_tb.sv
